// ----- design/lpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, register indexes and saturating Q8.24 helpers of the
// Lorenz point generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z   = 3'd6;

  localparam logic [30:0]        SIGMA_RST     = 31'd167772160;
  localparam logic [30:0]        BETA_RST      = 31'd30198989;
  localparam logic [30:0]        RHO_RST       = 31'd335544320;
  localparam logic [24:0]        TIME_STEP_RST = 25'd1678;
  localparam logic signed [31:0] START_X_RST   = 32'sd117440512;
  localparam logic signed [31:0] START_Y_RST   = 32'sd385875968;
  localparam logic signed [31:0] START_Z_RST   = 32'sd587202560;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0]        sigma;
    logic [30:0]        beta;
    logic [30:0]        rho;
    logic [24:0]        time_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } cfg_t;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  // Drop 24 fraction bits toward zero, then clamp to 32 bits.
  function automatic logic signed [31:0] q_trunc(logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd16777215 : 64'sd0);
    if (t[63:55] != {9{t[63]}}) begin
      return t[63] ? Q_MIN : Q_MAX;
    end
    return t[55:24];
  endfunction

  // Integer part of a Q11.24 value, clamped to 0..255.
  function automatic logic [7:0] chan8(logic signed [34:0] s);
    if (s[34]) begin
      return 8'd0;
    end
    if (|s[33:32]) begin
      return 8'hFF;
    end
    return s[31:24];
  endfunction

endpackage

// ----- design/lpg_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lpg_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [lpg_pkg::CFG_DATA_W-1:0]   data_i,
  output lpg_pkg::cfg_t                    cfg_o
);
  import lpg_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma     <= SIGMA_RST;
      cfg_q.beta      <= BETA_RST;
      cfg_q.rho       <= RHO_RST;
      cfg_q.time_step <= TIME_STEP_RST;
      cfg_q.start_x   <= START_X_RST;
      cfg_q.start_y   <= START_Y_RST;
      cfg_q.start_z   <= START_Z_RST;
    end else if (we_i) begin
      case (idx_i)
        CFG_SIGMA:     cfg_q.sigma     <= data_i[30:0];
        CFG_BETA:      cfg_q.beta      <= data_i[30:0];
        CFG_RHO:       cfg_q.rho       <= data_i[30:0];
        CFG_TIME_STEP: cfg_q.time_step <= data_i[24:0];
        CFG_START_X:   cfg_q.start_x   <= signed'(data_i);
        CFG_START_Y:   cfg_q.start_y   <= signed'(data_i);
        CFG_START_Z:   cfg_q.start_z   <= signed'(data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/lpg_qmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_qmul
// Shared Q8.24 multiplier: register the full product, then truncate
// toward zero, saturate and register the result.
// ----------------------------------------------------------------------------
module lpg_qmul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o
);
  import lpg_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [31:0] res_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    res_q  <= q_trunc(prod_q);
  end

  assign res_o = res_q;

endmodule

// ----- design/lorenz_point_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_point_generator
// One forward Euler step of a Lorenz system per request, Q8.24, with a
// packed display colour derived from the new point.
// ----------------------------------------------------------------------------
//   channel   signals                              direction
//   in        in_valid_i/in_ready_o, restart_i     request in
//   out       out_valid_o/out_ready_i, new_*_o,    result out
//             colour_o
//   cfg       cfg_we_i, cfg_idx_i, cfg_data_i      register write
//
// A request is accepted in the idle state and then runs a 12-step sequence
// driving eight products through one shared two-stage multiplier; the
// dependency chain through that multiplier sets the length. The result is
// valid once the last step completes, and in_ready_o rises with it.
// in_ready_o is high only while idle. The result register frees the input
// side; a new result waits in the last step while the previous one is held.
// Reset loads the default registers and clears the started flag.
// ----------------------------------------------------------------------------
module lorenz_point_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_x_o,
  output logic [31:0] new_y_o,
  output logic [31:0] new_z_o,
  output logic [23:0] colour_o
);
  import lpg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  localparam logic [3:0] ST_DS   = 4'd0;
  localparam logic [3:0] ST_RX   = 4'd1;
  localparam logic [3:0] ST_XZ   = 4'd2;
  localparam logic [3:0] ST_P1   = 4'd3;
  localparam logic [3:0] ST_XY   = 4'd4;
  localparam logic [3:0] ST_BZ   = 4'd5;
  localparam logic [3:0] ST_PY   = 4'd6;
  localparam logic [3:0] ST_WE   = 4'd7;
  localparam logic [3:0] ST_PZ   = 4'd8;
  localparam logic [3:0] ST_WP   = 4'd9;
  localparam logic [3:0] ST_FZ   = 4'd10;
  localparam logic [3:0] ST_LAST = 4'd11;

  cfg_t cfg;

  state_e state_q;
  logic [3:0] step_q;
  logic started_q;
  logic out_valid_q;

  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] d_q, ds_q, iy_q, iz_q;
  logic signed [31:0] nx_q, ny_q, nz_q;
  logic [31:0] new_x_q, new_y_q, new_z_q;
  logic [23:0] colour_q, colour_d;

  logic signed [31:0] op_a, op_b, mres;
  logic signed [31:0] dt_ext, sigma_ext, beta_ext, rho_ext;
  logic signed [34:0] red_s, green_s, blue_s;
  logic in_fire, out_free, running;

  lpg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  lpg_qmul u_qmul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .res_o (mres)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign running    = (state_q == S_RUN);

  assign dt_ext    = signed'({7'd0, cfg.time_step});
  assign sigma_ext = signed'({1'b0, cfg.sigma});
  assign beta_ext  = signed'({1'b0, cfg.beta});
  assign rho_ext   = signed'({1'b0, cfg.rho});

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      ST_DS: begin
        op_a = dt_ext;
        op_b = sigma_ext;
      end
      ST_RX: begin
        op_a = rho_ext;
        op_b = x_q;
      end
      ST_XZ: begin
        op_a = x_q;
        op_b = z_q;
      end
      ST_P1: begin
        op_a = ds_q;
        op_b = d_q;
      end
      ST_XY: begin
        op_a = x_q;
        op_b = y_q;
      end
      ST_BZ: begin
        op_a = beta_ext;
        op_b = z_q;
      end
      ST_PY: begin
        op_a = dt_ext;
        op_b = iy_q;
      end
      ST_PZ: begin
        op_a = dt_ext;
        op_b = iz_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    red_s   = ({{3{nz_q[31]}}, nz_q} <<< 2) + {{3{nz_q[31]}}, nz_q};
    green_s = 35'sd2147483648 + ({{3{nx_q[31]}}, nx_q} <<< 1)
              + {{3{nx_q[31]}}, nx_q};
    blue_s  = 35'sd2147483648 + ({{3{ny_q[31]}}, ny_q} <<< 1)
              + {{3{ny_q[31]}}, ny_q};
    colour_d = {chan8(red_s), chan8(green_s), chan8(blue_s)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_DS;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q   <= S_RUN;
            step_q    <= ST_DS;
            started_q <= 1'b1;
          end
        end
        S_RUN: begin
          if (step_q != ST_LAST) begin
            step_q <= step_q + 4'd1;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (running && (step_q == ST_LAST) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (restart_i || !started_q)) begin
      x_q <= cfg.start_x;
      y_q <= cfg.start_y;
      z_q <= cfg.start_z;
    end
    if (running) begin
      case (step_q)
        ST_DS: d_q  <= sat_sub(x_q, y_q);
        ST_XZ: ds_q <= mres;
        ST_P1: iy_q <= mres;
        ST_XY: iy_q <= sat_sub(iy_q, mres);
        ST_BZ: begin
          iy_q <= sat_sub(iy_q, y_q);
          nx_q <= sat_sub(x_q, mres);
        end
        ST_PY: iz_q <= mres;
        ST_WE: iz_q <= sat_sub(iz_q, mres);
        ST_PZ: ny_q <= sat_add(y_q, mres);
        ST_FZ: nz_q <= sat_add(z_q, mres);
        ST_LAST: begin
          if (out_free) begin
            x_q      <= nx_q;
            y_q      <= ny_q;
            z_q      <= nz_q;
            new_x_q  <= nx_q;
            new_y_q  <= ny_q;
            new_z_q  <= nz_q;
            colour_q <= colour_d;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign new_z_o     = new_z_q;
  assign colour_o    = colour_q;

endmodule
